// File: hdl/czs_pkg.sv
package czs_pkg;

  localparam int SampleW = 16;
  localparam int WeightW = 16;
  localparam int DeltaW  = 32;
  localparam int SpreadW = 16;
  localparam int OutW    = 32;

  localparam logic [1:0] CfgWeighted = 2'd0;
  localparam logic [1:0] CfgDelta    = 2'd1;
  localparam logic [1:0] CfgSpread   = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic store;      // write sample/weight at row_cnt, add to sum
    logic clr;        // clear accumulators
    logic mean_start; // start mean division
    logic sq_start;   // start square pass
    logic sqrt_start; // unused; var divide and sqrt follow sq_done
    logic row_start;  // start result computation for row idx
    logic out_load;   // load output register
    logic next_row;   // advance row index
  } czs_cmd_t;

  typedef struct packed {
    logic mean_done;
    logic sq_done;
    logic sqrt_done;
    logic row_done;
    logic last_idx;
    logic full;
  } czs_sts_t;

endpackage

// File: hdl/czs_if.sv
interface czs_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] sample;
  logic [15:0] weight;
  logic        last_row;
  modport source (output valid, sample, weight, last_row, input ready);
  modport sink (input valid, sample, weight, last_row, output ready);
endinterface

interface czs_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] scaled_value;
  logic [31:0] squared_value;
  logic [31:0] huber_threshold;
  logic [15:0] column_mean;
  logic [15:0] column_sd;
  logic        nonconstant;
  logic        row_last;
  modport source (output valid, scaled_value, squared_value, huber_threshold, column_mean,
                  column_sd, nonconstant, row_last, input ready);
  modport sink (input valid, scaled_value, squared_value, huber_threshold, column_mean,
                column_sd, nonconstant, row_last, output ready);
endinterface

// File: hdl/czs_divider.sv
// Restoring divider, one quotient bit per cycle.
module czs_divider #(
  parameter int NumW = 64,
  parameter int DenW = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic            done_o,
  output logic [NumW-1:0] quo_o
);
  localparam int CntW = $clog2(NumW + 1);

  logic [NumW-1:0] quo_q, quo_d;
  logic [DenW:0]   rem_q, rem_d;
  logic [DenW-1:0] den_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d, done_q, done_d;
  logic [DenW:0]   trial;
  logic [DenW:0]   shifted;

  always_comb begin
    shifted = {rem_q[DenW-1:0], quo_q[NumW-1]};
    trial   = shifted - {1'b0, den_q};
    quo_d   = quo_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (start_i) begin
      quo_d  = num_i;
      rem_d  = '0;
      cnt_d  = CntW'(NumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[DenW]) begin
        rem_d = trial;
        quo_d = {quo_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = shifted;
        quo_d = {quo_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (start_i) den_q <= den_i;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
endmodule

// File: hdl/czs_ctrl.sv
module czs_ctrl
  import czs_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_last_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  czs_sts_t sts_i,
  output czs_cmd_t cmd_o
);
  typedef enum logic [6:0] {
    StLoad = 7'b0000001,
    StMean = 7'b0000010,
    StSq   = 7'b0000100,
    StSqrt = 7'b0001000,
    StRow  = 7'b0010000,
    StOut  = 7'b0100000,
    StDone = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic   vld_q, vld_d;
  logic   acc;

  assign in_ready_o  = (state_q == StLoad);
  assign acc         = in_ready_o && in_valid_i;
  assign out_valid_o = vld_q;

  always_comb begin
    state_d = state_q;
    vld_d   = vld_q && !out_ready_i;
    cmd_o   = '0;
    unique case (state_q)
      StLoad: if (acc) begin
        cmd_o.store = !sts_i.full;
        if (in_last_i) begin
          state_d = StMean;
          cmd_o.mean_start = 1'b1;
        end
      end
      StMean: if (sts_i.mean_done) begin
        state_d = StSq;
        cmd_o.sq_start = 1'b1;
      end
      StSq: if (sts_i.sq_done) begin
        state_d = StSqrt;
        cmd_o.sqrt_start = 1'b1;
      end
      StSqrt: if (sts_i.sqrt_done) begin
        state_d = StRow;
        cmd_o.row_start = 1'b1;
      end
      StRow: if (sts_i.row_done) state_d = StOut;
      StOut: if (!vld_q || out_ready_i) begin
        cmd_o.out_load = 1'b1;
        vld_d = 1'b1;
        if (sts_i.last_idx) begin
          state_d = StDone;
        end else begin
          cmd_o.next_row  = 1'b1;
          cmd_o.row_start = 1'b1;
          state_d = StRow;
        end
      end
      StDone: if (!vld_q || out_ready_i) begin
        cmd_o.clr = 1'b1;
        state_d = StLoad;
      end
      default: state_d = StLoad;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StLoad;
      vld_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      vld_q   <= vld_d;
    end
  end
endmodule

// File: hdl/czs_datapath.sv
module czs_datapath
  import czs_pkg::*;
#(
  parameter int MaxRows = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  czs_cmd_t           cmd_i,
  output czs_sts_t           sts_o,
  input  logic [SampleW-1:0] sample_i,
  input  logic [WeightW-1:0] weight_i,
  input  logic               weighted_i,
  input  logic [DeltaW-1:0]  delta_i,
  input  logic [SpreadW-1:0] spread_i,
  output logic [OutW-1:0]    scaled_o,
  output logic [OutW-1:0]    squared_o,
  output logic [OutW-1:0]    thr_o,
  output logic [15:0]        mean_o,
  output logic [15:0]        sd_o,
  output logic               nonconst_o,
  output logic               last_o
);
  localparam int AddrW = $clog2(MaxRows);
  localparam int CntW  = $clog2(MaxRows + 1);

  logic [SampleW+WeightW-1:0] mem [MaxRows];
  logic [SampleW+WeightW-1:0] rd_q;
  logic [AddrW-1:0] rd_addr;

  logic [CntW-1:0]  cnt_q;
  logic [21:0]      sum_q;
  logic [39:0]      sqacc_q;
  logic [16:0]      mean_q;   // signed
  logic [15:0]      sd_q;
  logic             nc_q;
  logic [CntW-1:0]  idx_q;

  // mean divide starts once the last transfer has reached count and sum
  logic             mean_go_q;

  // square pass sequencing
  logic             sq_busy_q, sq_rd_q, sq_done_q;
  logic [CntW-1:0]  sq_idx_q;

  // shared divider
  logic         dv_start, dv_done;
  logic [63:0]  dv_num, dv_quo;
  logic [31:0]  dv_den;

  typedef enum logic [5:0] {
    PIdle = 6'b000001, PMean = 6'b000010, PVar = 6'b000100,
    PSqrt = 6'b001000, PScal = 6'b010000, PThr = 6'b100000
  } phase_e;
  phase_e ph_q;

  // sqrt state
  logic [39:0] rv_q, rroot_q, rbit_q;
  logic        sqrt_done_q;

  // row state
  logic        rpos_q, rneg_q, row_done_q, rmul_q, rrd_q;
  logic [33:0] prod_q;
  logic [30:0] m_q;
  logic [31:0] sqv_q;

  logic [21:0] abs_sum;
  assign abs_sum = sum_q[21] ? 22'(-sum_q) : sum_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.store) mem[cnt_q[AddrW-1:0]] <= {sample_i, weight_i};
    rd_q <= mem[rd_addr];
  end
  // next_row looks ahead so the read lands on the row being started
  assign rd_addr = sq_busy_q ? sq_idx_q[AddrW-1:0]
                             : idx_q[AddrW-1:0] + AddrW'(cmd_i.next_row);

  // centred sample of the registered read
  logic signed [17:0] dd;
  logic [16:0]        ad;
  assign dd = 18'(signed'(rd_q[31:16])) - 18'(signed'(mean_q));
  assign ad = dd[17] ? 17'(-dd) : 17'(dd);

  // sqrt step
  logic [39:0] rtry;
  assign rtry = rroot_q + rbit_q;

  logic [63:0] mm;
  assign mm = 64'(m_q) * 64'(m_q);

  always_comb begin
    dv_start = 1'b0;
    dv_num   = '0;
    dv_den   = '0;
    if (mean_go_q) begin
      dv_start = 1'b1;
      dv_num = 64'(abs_sum) + 64'(cnt_q >> 1);
      dv_den = 32'(cnt_q);
    end else if (sq_done_q) begin
      dv_start = 1'b1;
      dv_num = 64'(sqacc_q);
      dv_den = 32'(cnt_q);
    end else if (rmul_q) begin
      dv_start = nc_q;
      dv_num = 64'({prod_q, 8'h00});
      dv_den = 32'(sd_q);
    end else if (ph_q == PScal && dv_done && nc_q) begin
      dv_start = 1'b1;
      dv_num = {delta_i, 16'h0000};
      dv_den = (dv_quo > 64'h7FFFFFFF) ? 32'h7FFFFFFF : dv_quo[31:0];
    end
  end

  czs_divider #(.NumW(64), .DenW(32)) u_div (
    .clk_i, .rst_ni, .start_i(dv_start), .num_i(dv_num), .den_i(dv_den),
    .done_o(dv_done), .quo_o(dv_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0; sum_q <= '0; sqacc_q <= '0; idx_q <= '0;
      sq_busy_q <= 1'b0; sq_rd_q <= 1'b0; sq_done_q <= 1'b0; sq_idx_q <= '0;
      ph_q <= PIdle; sqrt_done_q <= 1'b0; row_done_q <= 1'b0;
      rmul_q <= 1'b0; rrd_q <= 1'b0; mean_go_q <= 1'b0;
    end else begin
      sq_done_q   <= 1'b0;
      sqrt_done_q <= 1'b0;
      row_done_q  <= 1'b0;
      rmul_q      <= 1'b0;
      rrd_q       <= 1'b0;
      mean_go_q   <= cmd_i.mean_start;
      if (cmd_i.store) begin
        cnt_q <= cnt_q + 1'b1;
        sum_q <= sum_q + 22'(signed'(sample_i));
      end
      if (cmd_i.clr) begin
        cnt_q <= '0; sum_q <= '0; sqacc_q <= '0; idx_q <= '0;
      end
      if (mean_go_q) ph_q <= PMean;
      if (ph_q == PMean && dv_done) begin
        mean_q <= sum_q[21] ? 17'(-dv_quo[16:0]) : dv_quo[16:0];
        ph_q <= PIdle;
      end
      // square pass: read one row per cycle, accumulate it in the cycle after
      if (cmd_i.sq_start) begin
        sq_busy_q <= 1'b1; sq_idx_q <= '0; sqacc_q <= '0;
      end
      if (sq_busy_q) begin
        sq_rd_q <= 1'b1;
        if (sq_idx_q == cnt_q - 1'b1) sq_busy_q <= 1'b0;
        else sq_idx_q <= sq_idx_q + 1'b1;
      end else begin
        sq_rd_q <= 1'b0;
      end
      if (sq_rd_q) begin
        sqacc_q <= sqacc_q + 40'(ad) * 40'(ad);
        if (!sq_busy_q) begin
          sq_done_q <= 1'b1;
          ph_q <= PVar;
        end
      end
      if (ph_q == PVar && dv_done) begin
        rv_q <= dv_quo[39:0]; rroot_q <= '0; rbit_q <= 40'h40_0000_0000;
        ph_q <= PSqrt;
      end
      if (ph_q == PSqrt) begin
        if (rbit_q == '0) begin
          sd_q <= (rroot_q > 40'hFFFF) ? 16'hFFFF : rroot_q[15:0];
          nc_q <= ((rroot_q > 40'hFFFF) ? 16'hFFFF : rroot_q[15:0]) > spread_i;
          sqrt_done_q <= 1'b1;
          ph_q <= PIdle;
        end else begin
          if (rv_q >= rtry) begin
            rv_q <= rv_q - rtry;
            rroot_q <= (rroot_q >> 1) + rbit_q;
          end else begin
            rroot_q <= rroot_q >> 1;
          end
          rbit_q <= rbit_q >> 2;
        end
      end
      if (cmd_i.next_row) idx_q <= idx_q + 1'b1;
      if (cmd_i.row_start) rrd_q <= 1'b1;
      if (rrd_q) begin
        rneg_q <= dd[17];
        prod_q <= 34'(ad) * 34'(weighted_i ? rd_q[15:0] : 16'd256);
        rmul_q <= 1'b1;
        if (!nc_q) row_done_q <= 1'b1;
      end
      if (rmul_q && nc_q) ph_q <= PScal;
      if (ph_q == PScal && dv_done) begin
        m_q <= (dv_quo > 64'h7FFFFFFF) ? 31'h7FFFFFFF : dv_quo[30:0];
        if (dv_quo == '0) begin
          ph_q <= PIdle;
          row_done_q <= 1'b1;
        end else begin
          ph_q <= PThr;
        end
      end
      if (ph_q == PThr && dv_done) begin
        ph_q <= PIdle;
        row_done_q <= 1'b1;
      end
    end
  end

  logic [63:0] thr_raw_q;
  always_ff @(posedge clk_i) begin
    if (ph_q == PThr && dv_done) thr_raw_q <= dv_quo;
    if (ph_q == PScal && dv_done && dv_quo == '0) thr_raw_q <= '1;
    sqv_q <= (mm[63:48] != '0) ? 32'hFFFFFFFF : mm[47:16];
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      if (nc_q) begin
        scaled_o  <= rneg_q ? 32'(-{1'b0, m_q}) : {1'b0, m_q};
        squared_o <= sqv_q;
        thr_o     <= (thr_raw_q[63:32] != '0) ? 32'hFFFFFFFF : thr_raw_q[31:0];
        mean_o    <= mean_q[15:0];
        sd_o      <= sd_q;
      end else begin
        scaled_o  <= '0;
        squared_o <= '0;
        thr_o     <= '1;
        mean_o    <= '0;
        sd_o      <= 16'd256;
      end
      nonconst_o <= nc_q;
      last_o     <= (idx_q == cnt_q - 1'b1);
    end
  end

  assign sts_o.mean_done = (ph_q == PMean) && dv_done;
  assign sts_o.sq_done   = sq_done_q;
  assign sts_o.sqrt_done = sqrt_done_q;
  assign sts_o.row_done  = row_done_q;
  assign sts_o.last_idx  = (idx_q == cnt_q - 1'b1);
  assign sts_o.full      = (cnt_q == CntW'(MaxRows));
endmodule

// File: hdl/column_zscore_standardizer_unit.sv
// Loads one sample per cycle while ready is high; results follow the last_row transfer.
// After last_row: mean divide, square pass, variance divide and square-root steps, then
// per row a scaling and a threshold divide (64-step divides sharing one unit).
// A new column is not accepted until every result of the current one has been taken.
// Asynchronous active-low reset clears the controller, counters and accumulators;
// configuration resets to weighted_mode 0, delta 65536, min_spread 1.
module column_zscore_standardizer_unit
  import czs_pkg::*;
#(
  parameter int MaxRows = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  czs_in_if.sink      in_if,
  czs_out_if.source   out_if,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i
);
  czs_cmd_t cmd;
  czs_sts_t sts;
  logic              weighted_q;
  logic [DeltaW-1:0] delta_q;
  logic [SpreadW-1:0] spread_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weighted_q <= 1'b0;
      delta_q    <= 32'd65536;
      spread_q   <= 16'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgWeighted: weighted_q <= cfg_data_i[0];
        CfgDelta:    delta_q    <= cfg_data_i;
        CfgSpread:   spread_q   <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  czs_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_if.valid), .in_last_i(in_if.last_row), .in_ready_o(in_if.ready),
    .out_valid_o(out_if.valid), .out_ready_i(out_if.ready),
    .sts_i(sts), .cmd_o(cmd)
  );

  czs_datapath #(.MaxRows(MaxRows)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .sample_i(in_if.sample), .weight_i(in_if.weight),
    .weighted_i(weighted_q), .delta_i(delta_q), .spread_i(spread_q),
    .scaled_o(out_if.scaled_value), .squared_o(out_if.squared_value),
    .thr_o(out_if.huber_threshold), .mean_o(out_if.column_mean),
    .sd_o(out_if.column_sd), .nonconst_o(out_if.nonconstant), .last_o(out_if.row_last)
  );
endmodule

// File: tb/tb.sv
module tb;
  import czs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          Rows       = 64;
  localparam int          CycleLimit = 2000000;
  localparam logic [1:0]  CfgUnused  = 2'd3;

  typedef struct packed {
    logic [31:0] scaled;
    logic [31:0] squared;
    logic [31:0] thresh;
    logic [15:0] mean;
    logic [15:0] sd;
    logic        nonconst;
    logic        last;
  } zrow_t;

  typedef struct packed {
    logic [15:0] sample;
    logic [15:0] weight;
    logic        last;
    logic        flat; // column ends as constant: summary fixed by definition
  } stim_row_t;

  logic clk;
  logic rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_idx;
  logic [31:0] cfg_data;

  czs_in_if  in_ch ();
  czs_out_if out_ch ();

  column_zscore_standardizer_unit dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_if      (in_ch),
    .out_if     (out_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  // shadow of the block's configuration and column state
  logic        cfg_weighted;
  logic [31:0] cfg_delta;
  logic [15:0] cfg_spread;
  logic [15:0] col_samples [Rows];
  logic [15:0] col_weights [Rows];
  int          rows_held;
  int          col_sum;

  zrow_t expected_rows [$];
  int    errors;
  int    cycles;
  bit    sink_quiet;
  bit    src_quiet;

  stim_row_t directed [] = '{
    '{16'sd100,  16'd256,   1'b1, 1'b1},  // one-row column
    '{16'h8000,  16'd256,   1'b0, 1'b0},
    '{16'h7fff,  16'd256,   1'b1, 1'b0},  // full-scale extremes
    '{16'd5,     16'd0,     1'b0, 1'b0},
    '{16'd5,     16'hffff,  1'b1, 1'b1},  // equal entries
    '{16'd0,     16'd0,     1'b0, 1'b0},
    '{16'd256,   16'hffff,  1'b0, 1'b0},
    '{-16'sd256, 16'd1,     1'b1, 1'b0},  // first row sits on the mean
    '{16'h8000,  16'h8000,  1'b0, 1'b0},
    '{16'h8000,  16'h0001,  1'b0, 1'b0},
    '{16'h8000,  16'h00ff,  1'b0, 1'b0},
    '{16'h7fff,  16'h7fff,  1'b1, 1'b0},
    '{16'd1,     16'd256,   1'b0, 1'b0},
    '{16'd0,     16'd256,   1'b1, 1'b1},  // spread below limit
    '{16'd0,     16'd256,   1'b0, 1'b0},
    '{16'd3,     16'd256,   1'b1, 1'b0}
  };

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned root;
    longint unsigned bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function automatic void apply_config(logic [1:0] idx, logic [31:0] data);
    case (idx)
      CfgWeighted: cfg_weighted = data[0];
      CfgDelta:    cfg_delta = data;
      CfgSpread:   cfg_spread = data[15:0];
      default: ;
    endcase
  endfunction

  // Stores one sample; on the last row works out the standardized column.
  function automatic void absorb_sample(logic [15:0] s, logic [15:0] w, logic last);
    int              n;
    longint          mean;
    longint          d;
    longint unsigned abs_sum, sqsum, sd, ad, wt, m, sqv, thr;
    bit              nc;
    zrow_t           r;
    if (rows_held < Rows) begin
      col_samples[rows_held] = s;
      col_weights[rows_held] = w;
      col_sum += int'($signed(s));
      rows_held++;
    end
    if (!last) return;
    n = rows_held;
    abs_sum = (col_sum < 0) ? -col_sum : col_sum;
    mean = (abs_sum + n / 2) / n;
    if (col_sum < 0) mean = -mean;
    sqsum = 0;
    for (int i = 0; i < n; i++) begin
      d = longint'($signed(col_samples[i])) - mean;
      sqsum += d * d;
    end
    sd = int_sqrt(sqsum / n);
    if (sd > 65535) sd = 65535;
    nc = sd > cfg_spread;
    for (int i = 0; i < n; i++) begin
      r = '0;
      r.thresh = '1;
      if (nc) begin
        d = longint'($signed(col_samples[i])) - mean;
        ad = (d < 0) ? -d : d;
        wt = cfg_weighted ? col_weights[i] : 256;
        m = ((ad * wt) << 8) / sd;
        if (m > 64'h7fffffff) m = 64'h7fffffff;
        r.scaled = (d < 0) ? 32'(0 - m) : 32'(m);
        sqv = (m * m) >> 16;
        r.squared = (sqv > 64'hffffffff) ? '1 : 32'(sqv);
        if (m != 0) begin
          thr = ({32'd0, cfg_delta} << 16) / m;
          r.thresh = (thr > 64'hffffffff) ? '1 : 32'(thr);
        end
        r.mean = 16'(mean);
        r.sd = 16'(sd);
      end else begin
        r.sd = 16'd256;
      end
      r.nonconst = nc;
      r.last = (i + 1 == n);
      expected_rows.push_back(r);
    end
    rows_held = 0;
    col_sum = 0;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
    if (exp_v !== got_v) begin
      $display("%0t: %s mismatch: expected %h, got %h", $time, name, exp_v, got_v);
      errors++;
    end
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout at %0t, %0d results outstanding", $time, expected_rows.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // result sink: checks every transfer and varies ready outside quiet phases
  int stall_left;
  always @(posedge clk) begin
    zrow_t exp_r;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_rows.size() == 0) begin
        $display("%0t: unexpected result, scaled %h", $time, out_ch.scaled_value);
        errors++;
      end else begin
        exp_r = expected_rows.pop_front();
        check_field("scaled_value", exp_r.scaled, out_ch.scaled_value);
        check_field("squared_value", exp_r.squared, out_ch.squared_value);
        check_field("huber_threshold", exp_r.thresh, out_ch.huber_threshold);
        check_field("column_mean", 32'(exp_r.mean), 32'(out_ch.column_mean));
        check_field("column_sd", 32'(exp_r.sd), 32'(out_ch.column_sd));
        check_field("nonconstant", 32'(exp_r.nonconst), 32'(out_ch.nonconstant));
        check_field("row_last", 32'(exp_r.last), 32'(out_ch.row_last));
      end
    end
    if (sink_quiet) begin
      out_ch.ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      stall_left <= gap_len();
      out_ch.ready <= 1'b1;
    end
  end

  task automatic send_sample(logic [15:0] s, logic [15:0] w, logic last);
    int gap;
    gap = src_quiet ? 0 : gap_len();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.sample <= s;
    in_ch.weight <= w;
    in_ch.last_row <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    absorb_sample(s, w, last);
  endtask

  // sender holds off until every outstanding result has been returned
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_rows.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    apply_config(idx, data);
  endtask

  task automatic random_column(int len);
    int          kind;
    logic [15:0] base, s, w;
    kind = $urandom_range(0, 9);
    base = 16'($urandom);
    for (int i = 0; i < len; i++) begin
      case (kind)
        0:       s = base;
        1, 2, 3: s = base + 16'($urandom_range(0, 64)) - 16'd32;
        4:       s = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
        default: s = 16'($urandom);
      endcase
      case ($urandom_range(0, 5))
        0:       w = $urandom_range(0, 1) ? 16'hffff : 16'h0000;
        1, 2:    w = 16'd256 + 16'($urandom_range(0, 128)) - 16'd64;
        default: w = 16'($urandom);
      endcase
      send_sample(s, w, i == len - 1);
    end
  endtask

  initial begin
    int sent;
    int len;
    int before_n;
    zrow_t r;
    errors = 0;
    cycles = 0;
    stall_left = 0;
    sink_quiet = 1'b0;
    src_quiet = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = CfgWeighted;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.sample = '0;
    in_ch.weight = '0;
    in_ch.last_row = 1'b0;
    out_ch.ready = 1'b0;
    cfg_weighted = 1'b0;
    cfg_delta = 32'd65536;
    cfg_spread = 16'd1;
    rows_held = 0;
    col_sum = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[k]) begin
      before_n = expected_rows.size();
      send_sample(directed[k].sample, directed[k].weight, directed[k].last);
      if (directed[k].flat) begin
        for (int j = before_n; j < expected_rows.size(); j++) begin
          r = expected_rows[j];
          r.scaled = '0;
          r.squared = '0;
          r.thresh = '1;
          r.mean = '0;
          r.sd = 16'd256;
          r.nonconst = 1'b0;
          expected_rows[j] = r;
        end
      end
    end
    drain();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          write_reg(CfgWeighted, 32'd1);
          write_reg(CfgUnused, 32'hffffffff);
        end
        1: begin
          write_reg(CfgDelta, 32'd0);
          write_reg(CfgSpread, 32'd0);
        end
        2: begin
          write_reg(CfgWeighted, 32'd0);
          write_reg(CfgDelta, 32'hffffffff);
        end
        3: begin
          write_reg(CfgWeighted, 32'd1);
          write_reg(CfgSpread, 32'd65535);
        end
        4: begin
          write_reg(CfgDelta, $urandom);
          write_reg(CfgSpread, $urandom_range(0, 300));
        end
        default: begin
          write_reg(CfgWeighted, 32'($urandom_range(0, 1)));
          write_reg(CfgDelta, 32'd65536);
          write_reg(CfgSpread, 32'd1);
        end
      endcase
      src_quiet = (phase == 2);
      sink_quiet = (phase == 4);
      sent = 0;
      while (sent < 80) begin
        if (phase == 1 && sent == 0) len = 67;  // overflows the store
        else if ($urandom_range(0, 24) == 0) len = $urandom_range(40, 64);
        else if ($urandom_range(0, 9) == 0) len = 1;
        else len = $urandom_range(2, 10);
        random_column(len);
        sent += len;
        if ($urandom_range(0, 7) == 0) drain();
      end
      drain();
    end

    if (errors == 0 && expected_rows.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, expected_rows.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
